@@ hdl/serial_adc_24bit_readout_macros.svh @@
// Assertion macros shared by the readout checker.
// No dependencies; included by bare file name.
`ifndef SERIAL_ADC_24BIT_READOUT_MACROS_SVH
`define SERIAL_ADC_24BIT_READOUT_MACROS_SVH

// Check a property outside reset.
`define SADC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SADC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sadc_pkg.sv @@
// Shared constants, types and field positions for the serial ADC readout.
// No dependencies.
package sadc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_WIDTH = 8;
  localparam int BIT_IDX_W   = $clog2(SAMPLE_BITS);
  localparam int READING_W   = 26;
  localparam int CFG_W       = 8;
  localparam int OFFSET_W    = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int IN_W          = 8;
  localparam int OUT_FIELDS_W  = 3 + READING_W;
  localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_W - OUT_FIELDS_W;

  localparam int IN_START_BIT   = 0;
  localparam int IN_CHANNEL_BIT = 1;
  localparam int IN_PIN_A_BIT   = 2;
  localparam int IN_PIN_B_BIT   = 3;

  localparam int OUT_CLOCK_BIT = 0;
  localparam int OUT_BUSY_BIT  = 1;
  localparam int OUT_VALID_BIT = 2;
  localparam int OUT_READ_LSB  = 3;
  localparam int OUT_READ_MSB  = OUT_READ_LSB + READING_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd4;

  localparam logic [CFG_W-1:0]    RST_WAIT_LOW  = 8'd36;
  localparam logic [CFG_W-1:0]    RST_WAIT_HIGH = 8'd12;
  localparam logic [CFG_W-1:0]    RST_SETTLE    = 8'd3;
  localparam logic [CFG_W-1:0]    RST_HALF      = 8'd3;
  localparam logic [OFFSET_W-1:0] RST_OFFSET    = 24'd5230000;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_EDGE   = 3'd1,
    PH_DELAY  = 3'd2,
    PH_SETTLE = 3'd3,
    PH_HIGH   = 3'd4,
    PH_LOW    = 3'd5
  } sadc_phase_t;

  typedef struct packed {
    logic [CFG_W-1:0]    wait_after_low;
    logic [CFG_W-1:0]    wait_after_high;
    logic [CFG_W-1:0]    settle_ticks;
    logic [CFG_W-1:0]    half_period;
    logic [OFFSET_W-1:0] result_offset;
  } sadc_cfg_t;

  typedef struct packed {
    logic                        clock_level;
    logic                        busy_res;
    logic                        sample_valid;
    logic signed [READING_W-1:0] reading;
  } sadc_res_t;

  function automatic logic [COUNT_WIDTH-1:0] to_cnt(input logic [CFG_W-1:0] v);
    return COUNT_WIDTH'(v);
  endfunction

endpackage

@@ hdl/sadc_seq.sv @@
// Tick sequencer: phase control, tick counter, bit shifter and result conversion.
// Depends on sadc_pkg.
module sadc_seq
  import sadc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic      start_req,
  input  logic      channel,
  input  logic      data_pin_a,
  input  logic      data_pin_b,
  input  sadc_cfg_t cfg,
  output sadc_res_t res
);

  sadc_phase_t                phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]     cnt_r, cnt_nxt;
  logic [BIT_IDX_W-1:0]       bit_r, bit_nxt;
  logic [SAMPLE_BITS-1:0]     shift_r, shift_nxt;
  logic                       lch_r, lch_nxt;
  logic                       first_r, first_nxt;
  logic                       clk_r, clk_nxt;

  logic                       pin;
  logic [COUNT_WIDTH-1:0]     half_cnt;
  logic [COUNT_WIDTH-1:0]     settle_cnt;
  logic [COUNT_WIDTH-1:0]     wait_cnt;
  logic                       cnt_last;
  logic                       last_bit;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [READING_W-1:0]       off_ext;
  logic [READING_W-1:0]       conv;
  logic                       valid;

  assign pin        = lch_r ? data_pin_b : data_pin_a;
  assign half_cnt   = (to_cnt(cfg.half_period) == '0) ? COUNT_WIDTH'(1)
                                                       : to_cnt(cfg.half_period);
  assign settle_cnt = to_cnt(cfg.settle_ticks);
  assign wait_cnt   = first_r ? to_cnt(cfg.wait_after_high) : to_cnt(cfg.wait_after_low);
  assign cnt_last   = (cnt_r == COUNT_WIDTH'(1));
  assign last_bit   = (bit_r >= BIT_IDX_W'(SAMPLE_BITS - 1));
  assign mag        = ~shift_r;
  assign off_ext    = READING_W'(cfg.result_offset);
  assign conv       = shift_r[SAMPLE_BITS-1] ? (off_ext - READING_W'(mag))
                                             : (off_ext + READING_W'(shift_r));

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) phase_nxt = PH_EDGE;
      end
      PH_EDGE: begin
        if (pin != first_r) begin
          if (wait_cnt != '0)        phase_nxt = PH_DELAY;
          else if (settle_cnt != '0) phase_nxt = PH_SETTLE;
          else                       phase_nxt = PH_HIGH;
        end
      end
      PH_DELAY: begin
        if (cnt_last) phase_nxt = (settle_cnt != '0) ? PH_SETTLE : PH_HIGH;
      end
      PH_SETTLE: begin
        if (cnt_last) phase_nxt = PH_HIGH;
      end
      PH_HIGH: begin
        if (cnt_last) phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        if (cnt_last) phase_nxt = last_bit ? PH_IDLE : PH_HIGH;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    lch_nxt   = lch_r;
    first_nxt = first_r;
    clk_nxt   = clk_r;
    valid     = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          lch_nxt   = channel;
          clk_nxt   = 1'b0;
          first_nxt = channel ? data_pin_b : data_pin_a;
          shift_nxt = '0;
          bit_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      PH_EDGE: begin
        if (pin != first_r) begin
          if (wait_cnt != '0) begin
            cnt_nxt = wait_cnt;
          end else if (settle_cnt != '0) begin
            cnt_nxt = settle_cnt;
          end else begin
            cnt_nxt = half_cnt;
            clk_nxt = 1'b1;
          end
        end
      end
      PH_DELAY: begin
        cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        if (cnt_last) begin
          if (settle_cnt != '0) begin
            cnt_nxt = settle_cnt;
          end else begin
            cnt_nxt = half_cnt;
            clk_nxt = 1'b1;
          end
        end
      end
      PH_SETTLE: begin
        cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        if (cnt_last) begin
          cnt_nxt = half_cnt;
          clk_nxt = 1'b1;
        end
      end
      PH_HIGH: begin
        cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        if (cnt_last) begin
          shift_nxt = {shift_r[SAMPLE_BITS-2:0], pin};
          clk_nxt   = 1'b0;
          cnt_nxt   = half_cnt;
        end
      end
      PH_LOW: begin
        cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        if (cnt_last) begin
          if (last_bit) begin
            valid   = 1'b1;
            bit_nxt = '0;
          end else begin
            bit_nxt = bit_r + BIT_IDX_W'(1);
            cnt_nxt = half_cnt;
            clk_nxt = 1'b1;
          end
        end
      end
      default: clk_nxt = 1'b0;
    endcase
  end

  always_comb begin
    res.clock_level  = clk_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.sample_valid = valid;
    res.reading      = valid ? signed'(conv) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      lch_r   <= 1'b0;
      first_r <= 1'b0;
      clk_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      lch_r   <= lch_nxt;
      first_r <= first_nxt;
      clk_r   <= clk_nxt;
    end
  end

endmodule

@@ hdl/serial_adc_24bit_readout.sv @@
// Two-channel serial delta-sigma ADC readout, 24-bit samples, tick driven.
// Each input transfer is one timing tick and yields exactly one output transfer,
// registered, carrying the serial clock level, busy flag and, on the final tick
// of a read, the converted reading. One tick is taken every clock cycle while
// in_tready is high: the sequencer state advances in a single pass per tick and
// the result lands in an output register backed by a one-entry skid stage, so
// in_tready falls only when both hold results the downstream side has not yet
// taken. Configuration writes are registered and are to be made while no read
// is in progress. Depends on sadc_pkg and sadc_seq.
module serial_adc_24bit_readout
  import sadc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] start_req, [1] channel, [2] data_pin_a, [3] data_pin_b
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] clock_level, [1] busy_res, [2] sample_valid, [28:3] reading
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sadc_cfg_t        cfg_r;
  sadc_res_t        res;
  logic [OUT_W-1:0] res_word;
  logic             push;
  logic             take;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             skid_valid_r;
  logic [OUT_W-1:0] skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_after_low  <= RST_WAIT_LOW;
      cfg_r.wait_after_high <= RST_WAIT_HIGH;
      cfg_r.settle_ticks    <= RST_SETTLE;
      cfg_r.half_period     <= RST_HALF;
      cfg_r.result_offset   <= RST_OFFSET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WAIT_LOW:  cfg_r.wait_after_low  <= cfg_data[CFG_W-1:0];
        CFG_WAIT_HIGH: cfg_r.wait_after_high <= cfg_data[CFG_W-1:0];
        CFG_SETTLE:    cfg_r.settle_ticks    <= cfg_data[CFG_W-1:0];
        CFG_HALF:      cfg_r.half_period     <= cfg_data[CFG_W-1:0];
        CFG_OFFSET:    cfg_r.result_offset   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign take      = out_valid_r && out_tready;

  sadc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (push),
    .start_req  (in_tdata[IN_START_BIT]),
    .channel    (in_tdata[IN_CHANNEL_BIT]),
    .data_pin_a (in_tdata[IN_PIN_A_BIT]),
    .data_pin_b (in_tdata[IN_PIN_B_BIT]),
    .cfg        (cfg_r),
    .res        (res)
  );

  assign res_word = {{OUT_PAD_W{1'b0}}, res.reading, res.sample_valid,
                     res.busy_res, res.clock_level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_data_r <= skid_data_r;
    end else if (!out_valid_r || take) begin
      if (push) out_data_r <= res_word;
    end else if (push) begin
      skid_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/sadc_checker.sv @@
// Port-level checker for the serial ADC readout, bound to the top level.
// Depends on sadc_pkg and serial_adc_24bit_readout_macros.svh.
`include "serial_adc_24bit_readout_macros.svh"

module sadc_checker
  import sadc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  `SADC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output transfer changed")
  `SADC_ASSERT(a_in_to_out, in_tvalid && in_tready |=> out_tvalid, "accepted tick produced no output")
  `SADC_ASSERT(a_done_idle, out_tvalid |-> !(out_tdata[OUT_VALID_BIT] && out_tdata[OUT_BUSY_BIT]), "reading presented while busy")
  `SADC_ASSERT(a_read_zero, out_tvalid && !out_tdata[OUT_VALID_BIT] |-> out_tdata[OUT_READ_MSB:OUT_READ_LSB] == '0, "reading nonzero without sample_valid")
  `SADC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind serial_adc_24bit_readout sadc_checker u_sadc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
